// ----- hdl/dwc_pkg.sv -----
// ----------------------------------------------------------------------------
// dwc_pkg
// shared constants, codes and transaction types of the depthwise conv core
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int DEF_MAX_CHANNELS = 64;
    localparam int DEF_MAX_TAPS     = 16;
    localparam int DEF_WINDOW_DEPTH = 128;
    localparam int DEF_MAX_WIDTH    = 4096;

    localparam int KIND_W     = 2;
    localparam int CH_W       = 6;
    localparam int TAP_W      = 4;
    localparam int VAL_W      = 32;
    localparam int POS_W      = 13;
    localparam int SUM_W      = 40;
    localparam int SMP_W      = 16;
    localparam int PROD_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int OP_TAP_W   = 6;
    localparam int RESULT_LIMIT = 31;
    localparam int CNT_N_W    = 5;
    localparam int STRIDE_MAX = 8;
    localparam int DIL_MAX    = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_SAMPLE = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_WIDTH    = 3'd0,
        CFG_KERNEL_SIZE = 3'd1,
        CFG_STRIDE      = 3'd2,
        CFG_DILATION    = 3'd3,
        CFG_PAD_LEFT    = 3'd4,
        CFG_PAD_RIGHT   = 3'd5,
        CFG_BIAS_ENABLE = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_POS,
        ST_TEST,
        ST_MOD,
        ST_TAP
    } t_state;

    typedef struct packed {
        logic                    valid;
        logic [OP_TAP_W-1:0]     tap;
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] w;
        logic [CH_W-1:0]         ch;
        logic [POS_W-1:0]        pos;
        logic                    last;
        logic signed [SUM_W-1:0] bias;
    } t_op;

    typedef struct packed {
        logic                    valid;
        logic [CH_W-1:0]         ch;
        logic [POS_W-1:0]        pos;
        logic                    last;
        logic signed [SUM_W-1:0] sum;
    } t_lane;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [VAL_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > 32'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -32'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hdl/dwc_in_if.sv -----
// ----------------------------------------------------------------------------
// dwc_in_if
// input channel: weight loads, bias loads and row samples
// ----------------------------------------------------------------------------
interface dwc_in_if;
    import dwc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [CH_W-1:0]         channel;
    logic [TAP_W-1:0]        tap;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, kind, channel, tap, value, input ready);
    modport sink   (input valid, kind, channel, tap, value, output ready);
endinterface

// ----- hdl/dwc_out_if.sv -----
// ----------------------------------------------------------------------------
// dwc_out_if
// result channel: one convolution output per transaction
// ----------------------------------------------------------------------------
interface dwc_out_if;
    import dwc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CH_W-1:0]         out_channel;
    logic [POS_W-1:0]        position;
    logic signed [SUM_W-1:0] sum_value;
    logic                    last_of_row;

    modport source (output valid, out_channel, position, sum_value, last_of_row, input ready);
    modport sink   (input valid, out_channel, position, sum_value, last_of_row, output ready);
endinterface

// ----- hdl/dwc_cell.sv -----
// ----------------------------------------------------------------------------
// dwc_cell
// one tap of the accumulation chain: adds its product to the passing sum
// ----------------------------------------------------------------------------
module dwc_cell #(
    parameter int TAP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  dwc_pkg::t_lane i_lane,
    input  dwc_pkg::t_op   i_op,
    output dwc_pkg::t_lane o_lane
);
    import dwc_pkg::*;

    logic                     hit;
    logic signed [PROD_W-1:0] prod;
    t_lane                    n_lane;
    t_lane                    r_lane;

    assign hit  = i_op.valid && (i_op.tap == OP_TAP_W'(TAP));
    assign prod = i_op.x * i_op.w;

    always_comb begin
        n_lane = i_lane;
        if (hit) begin
            n_lane.sum = i_lane.sum + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_adv) begin
            r_lane.valid <= n_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_lane.ch   <= n_lane.ch;
            r_lane.pos  <= n_lane.pos;
            r_lane.last <= n_lane.last;
            r_lane.sum  <= n_lane.sum;
        end
    end

    assign o_lane = r_lane;
endmodule

// ----- hdl/dwc_chain.sv -----
// ----------------------------------------------------------------------------
// dwc_chain
// row of tap cells; while i_adv is high, a partial sum walks one cell per cycle
// ----------------------------------------------------------------------------
module dwc_chain #(
    parameter int MAX_TAPS = dwc_pkg::DEF_MAX_TAPS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  dwc_pkg::t_op   i_op,
    output dwc_pkg::t_lane o_tail
);
    import dwc_pkg::*;

    t_lane w_head;
    t_lane w_lane [MAX_TAPS];

    always_comb begin
        w_head.valid = i_op.valid && (i_op.tap == '0);
        w_head.ch    = i_op.ch;
        w_head.pos   = i_op.pos;
        w_head.last  = i_op.last;
        w_head.sum   = i_op.bias;
    end

    for (genvar gi = 0; gi < MAX_TAPS; gi++) begin : g_cell
        if (gi == 0) begin : g_first
            dwc_cell #(.TAP(gi)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_adv  (i_adv),
                .i_lane (w_head),
                .i_op   (i_op),
                .o_lane (w_lane[gi])
            );
        end else begin : g_next
            dwc_cell #(.TAP(gi)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_adv  (i_adv),
                .i_lane (w_lane[gi-1]),
                .i_op   (i_op),
                .o_lane (w_lane[gi])
            );
        end
    end

    assign o_tail = w_lane[MAX_TAPS-1];
endmodule

// ----- hdl/depthwise_conv1d_forward_core.sv -----
// ----------------------------------------------------------------------------
// depthwise_conv1d_forward_core
// depthwise 1-d convolution with stride, dilation, padding and bias
// ----------------------------------------------------------------------------
// usage
//   i_in carries weight loads, bias loads and row samples; o_out carries one
//   convolution output per transaction; i_cfg_we/idx/data write the registers
//   while the core is idle; the user is bound, the core does not enforce it.
//   weight and bias loads keep the core idle. a sample is written to the
//   window, then each output that it completes is built by the sequencer:
//   checks in ST_TEST after ST_POS, a slot lookup (direct for a power-of-two
//   window, else a bitwise remainder), then one tap a cycle, while o_out is
//   not stalled, issued from the window and weight memories into the tap
//   cell chain. i_in.ready is low from an accepted sample until idle again.
//   each output passes the tap issue register, tap cells and output register.
//   reset clears the sample count and output position and loads the
//   register defaults; weights and biases must be loaded before use.
//   when o_out stalls, the chain and the tap issue freeze; no output is lost.
// ----------------------------------------------------------------------------
module depthwise_conv1d_forward_core #(
    parameter int MAX_CHANNELS = dwc_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_TAPS     = dwc_pkg::DEF_MAX_TAPS,
    parameter int WINDOW_DEPTH = dwc_pkg::DEF_WINDOW_DEPTH,
    parameter int MAX_WIDTH    = dwc_pkg::DEF_MAX_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dwc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dwc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    dwc_in_if.sink                           i_in,
    dwc_out_if.source                        o_out
);
    import dwc_pkg::*;

    localparam int WSZ  = MAX_CHANNELS * MAX_TAPS;
    localparam int WA_W = (WSZ > 1) ? $clog2(WSZ) : 1;
    localparam int CI_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int KW   = $clog2(MAX_TAPS + 1);
    localparam int PW   = $clog2(MAX_WIDTH + 31);
    localparam int AW   = PW + 12;
    localparam int LW   = $clog2(WINDOW_DEPTH);
    localparam int MCW  = $clog2(AW);
    localparam bit POW2 = ((WINDOW_DEPTH & (WINDOW_DEPTH - 1)) == 0);

    // configuration registers
    logic [12:0] r_in_width;
    logic [4:0]  r_kernel;
    logic [3:0]  r_stride;
    logic [3:0]  r_dil;
    logic [3:0]  r_pad_l;
    logic [3:0]  r_pad_r;
    logic        r_bias_en;

    // memories
    logic signed [SMP_W-1:0] r_weight_mem [WSZ];
    logic signed [VAL_W-1:0] r_bias_mem   [MAX_CHANNELS];
    logic signed [SMP_W-1:0] r_win_mem    [WINDOW_DEPTH];

    // sequencer
    t_state               r_state, n_state;
    logic [WW-1:0]        r_cnt;
    logic [LW-1:0]        r_wslot;
    logic [PW-1:0]        r_pos;
    logic [CNT_N_W-1:0]   r_n;
    logic [CH_W-1:0]      r_ch;
    logic [WA_W-1:0]      r_wbase;
    logic signed [VAL_W-1:0] r_bias;
    logic [WW-1:0]        r_wid;
    logic [KW-1:0]        r_kn;
    logic [3:0]           r_st;
    logic [3:0]           r_dl;
    logic [3:0]           r_pl;
    logic [AW-1:0]        r_span;
    logic [AW-1:0]        r_effin;
    logic signed [SUM_W-1:0] r_bias_add;
    logic [AW-1:0]        r_s;
    logic                 r_last;
    logic [AW-1:0]        r_v;
    logic [LW-1:0]        r_rem;
    logic [MCW-1:0]       r_mcnt;
    logic [LW-1:0]        r_slot;
    logic signed [AW:0]   r_iw;
    logic [KW-1:0]        r_k;

    // tap issue stage
    logic                    r_op_valid;
    logic [OP_TAP_W-1:0]     r_op_tap;
    logic                    r_op_use;
    logic [CH_W-1:0]         r_op_ch;
    logic [POS_W-1:0]        r_op_pos;
    logic                    r_op_last;
    logic signed [SUM_W-1:0] r_op_bias;
    logic signed [SMP_W-1:0] r_x;
    logic signed [SMP_W-1:0] r_wrd;

    // output register
    logic  r_out_valid;
    t_lane r_out;

    logic        in_acc, ch_ok, tap_ok, adv, go, row_end, issue, tap_done, mod_done;
    t_kind       kind;
    logic [31:0] w_waddr32, w_base32, w_ch32, w_pos32;
    logic [31:0] c_w32, c_kn32, c_span32, c_effin32;
    logic [3:0]  c_st, c_dl;
    logic [AW-1:0] t_sspan, t_li, t_wm1, t_lic;
    logic          brk;
    logic signed [AW:0] t_iw0;
    logic [LW:0]   t_rem2, t_rem_nx, t_slot_nx;
    logic          use_tap;
    logic [KW-1:0] kn_m1;
    t_op           w_op;
    t_lane         w_tail;

    assign kind      = t_kind'(i_in.kind);
    assign in_acc    = i_in.valid && i_in.ready;
    assign w_ch32    = 32'(i_in.channel);
    assign ch_ok     = w_ch32 < MAX_CHANNELS;
    assign tap_ok    = 32'(i_in.tap) < MAX_TAPS;
    assign w_base32  = w_ch32 * MAX_TAPS;
    assign w_waddr32 = w_base32 + 32'(i_in.tap);
    assign i_in.ready = (r_state == ST_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width <= 13'd16;
            r_kernel   <= 5'd3;
            r_stride   <= 4'd1;
            r_dil      <= 4'd1;
            r_pad_l    <= 4'd0;
            r_pad_r    <= 4'd0;
            r_bias_en  <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IN_WIDTH:    r_in_width <= i_cfg_data[12:0];
                CFG_KERNEL_SIZE: r_kernel   <= i_cfg_data[4:0];
                CFG_STRIDE:      r_stride   <= i_cfg_data[3:0];
                CFG_DILATION:    r_dil      <= i_cfg_data[3:0];
                CFG_PAD_LEFT:    r_pad_l    <= i_cfg_data[3:0];
                CFG_PAD_RIGHT:   r_pad_r    <= i_cfg_data[3:0];
                CFG_BIAS_ENABLE: r_bias_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (in_acc && kind == KIND_WEIGHT && ch_ok && tap_ok) begin
            r_weight_mem[w_waddr32[WA_W-1:0]] <= sat16(i_in.value);
        end
        if (in_acc && kind == KIND_BIAS && ch_ok) begin
            r_bias_mem[w_ch32[CI_W-1:0]] <= i_in.value;
        end
        if (in_acc && kind == KIND_SAMPLE && ch_ok) begin
            r_win_mem[r_wslot] <= sat16(i_in.value);
        end
    end

    // register clamps
    always_comb begin
        if (r_in_width == '0) begin
            c_w32 = 32'd1;
        end else if (32'(r_in_width) > MAX_WIDTH) begin
            c_w32 = 32'(MAX_WIDTH);
        end else begin
            c_w32 = 32'(r_in_width);
        end
        if (r_kernel == '0) begin
            c_kn32 = 32'd1;
        end else if (32'(r_kernel) > MAX_TAPS) begin
            c_kn32 = 32'(MAX_TAPS);
        end else begin
            c_kn32 = 32'(r_kernel);
        end
        if (r_stride == '0) begin
            c_st = 4'd1;
        end else if (32'(r_stride) > STRIDE_MAX) begin
            c_st = 4'(STRIDE_MAX);
        end else begin
            c_st = r_stride;
        end
        if (r_dil == '0) begin
            c_dl = 4'd1;
        end else if (32'(r_dil) > DIL_MAX) begin
            c_dl = 4'(DIL_MAX);
        end else begin
            c_dl = r_dil;
        end
        c_span32  = (c_kn32 - 32'd1) * 32'(c_dl);
        c_effin32 = c_w32 + 32'(r_pad_l) + 32'(r_pad_r);
    end

    // output window checks
    always_comb begin
        t_sspan = r_s + r_span;
        t_wm1   = AW'(r_wid) - AW'(1);
        t_li    = t_sspan - AW'(r_pl);
        t_lic   = (t_li > t_wm1) ? t_wm1 : t_li;
        brk     = (t_sspan >= AW'(r_pl)) && (t_lic >= AW'(r_cnt));
        go      = (t_sspan < r_effin) && (32'(r_n) < RESULT_LIMIT) && !brk;
        row_end = r_cnt >= r_wid;
        t_iw0   = $signed({1'b0, r_s}) - $signed({{(AW-3){1'b0}}, r_pl});
    end

    // slot arithmetic
    always_comb begin
        t_rem2   = {r_rem, r_v[AW-1]};
        t_rem_nx = (t_rem2 >= (LW+1)'(WINDOW_DEPTH)) ? t_rem2 - (LW+1)'(WINDOW_DEPTH) : t_rem2;
        t_slot_nx = {1'b0, r_slot} + (LW+1)'(r_dl);
        if (t_slot_nx >= (LW+1)'(WINDOW_DEPTH)) begin
            t_slot_nx = t_slot_nx - (LW+1)'(WINDOW_DEPTH);
        end
        use_tap = (r_iw >= 0) && (r_iw < $signed({1'b0, AW'(r_wid)}))
               && (r_iw < $signed({1'b0, AW'(r_cnt)}));
        kn_m1   = r_kn - KW'(1);
    end

    assign adv      = !r_out_valid || o_out.ready;
    assign issue    = (r_state == ST_TAP) && adv;
    assign tap_done = issue && (r_k == kn_m1);
    assign mod_done = POW2 || (r_mcnt == MCW'(AW - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && kind == KIND_SAMPLE && ch_ok) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: n_state = ST_POS;
            ST_POS:  n_state = ST_TEST;
            ST_TEST: n_state = go ? ST_MOD : ST_IDLE;
            ST_MOD: begin
                if (mod_done) begin
                    n_state = ST_TAP;
                end
            end
            ST_TAP: begin
                if (tap_done) begin
                    n_state = ST_POS;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // row counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wslot <= '0;
            r_pos   <= '0;
            r_n     <= '0;
        end else begin
            if (r_state == ST_IDLE && in_acc && kind == KIND_SAMPLE && ch_ok) begin
                r_cnt   <= r_cnt + WW'(1);
                r_wslot <= (r_wslot == LW'(WINDOW_DEPTH - 1)) ? '0 : r_wslot + LW'(1);
                r_n     <= '0;
            end else if (r_state == ST_TEST && !go && row_end) begin
                r_cnt   <= '0;
                r_wslot <= '0;
                r_pos   <= '0;
            end else if (tap_done) begin
                r_pos <= r_pos + PW'(1);
                r_n   <= r_n + CNT_N_W'(1);
            end
        end
    end

    // per-item and per-output datapath
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_ch    <= i_in.channel;
            r_wbase <= w_base32[WA_W-1:0];
            r_bias  <= r_bias_mem[w_ch32[CI_W-1:0]];
        end
        case (r_state)
            ST_PREP: begin
                r_wid      <= c_w32[WW-1:0];
                r_kn       <= c_kn32[KW-1:0];
                r_st       <= c_st;
                r_dl       <= c_dl;
                r_pl       <= r_pad_l;
                r_span     <= c_span32[AW-1:0];
                r_effin    <= c_effin32[AW-1:0];
                r_bias_add <= r_bias_en ? {{(SUM_W-VAL_W){r_bias[VAL_W-1]}}, r_bias} : '0;
            end
            ST_POS: begin
                r_s <= AW'(r_pos) * AW'(r_st);
            end
            ST_TEST: begin
                r_last <= (t_sspan + AW'(r_st)) >= r_effin;
                r_v    <= r_s + AW'(WINDOW_DEPTH) - AW'(r_pl);
                r_rem  <= '0;
                r_mcnt <= '0;
                r_iw   <= t_iw0;
                r_k    <= '0;
            end
            ST_MOD: begin
                if (POW2) begin
                    r_slot <= r_v[LW-1:0];
                end else begin
                    r_rem  <= t_rem_nx[LW-1:0];
                    r_v    <= r_v << 1;
                    r_mcnt <= r_mcnt + MCW'(1);
                    if (mod_done) begin
                        r_slot <= t_rem_nx[LW-1:0];
                    end
                end
            end
            ST_TAP: begin
                if (adv) begin
                    r_iw   <= r_iw + $signed({{(AW-3){1'b0}}, r_dl});
                    r_slot <= t_slot_nx[LW-1:0];
                    r_k    <= r_k + KW'(1);
                end
            end
            default: ;
        endcase
    end

    // tap issue stage, memory reads registered
    assign w_pos32 = 32'(r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_valid <= 1'b0;
        end else if (adv) begin
            r_op_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_op_tap  <= OP_TAP_W'(r_k);
            r_op_use  <= use_tap;
            r_op_ch   <= r_ch;
            r_op_pos  <= w_pos32[POS_W-1:0];
            r_op_last <= r_last;
            r_op_bias <= r_bias_add;
            r_x       <= r_win_mem[r_slot];
            r_wrd     <= r_weight_mem[r_wbase + WA_W'(r_k)];
        end
    end

    always_comb begin
        w_op.valid = r_op_valid;
        w_op.tap   = r_op_tap;
        w_op.x     = r_op_use ? r_x : '0;
        w_op.w     = r_wrd;
        w_op.ch    = r_op_ch;
        w_op.pos   = r_op_pos;
        w_op.last  = r_op_last;
        w_op.bias  = r_op_bias;
    end

    dwc_chain #(.MAX_TAPS(MAX_TAPS)) u_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_adv  (adv),
        .i_op   (w_op),
        .o_tail (w_tail)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= w_tail.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= w_tail;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out.ch;
    assign o_out.position    = r_out.pos;
    assign o_out.sum_value   = r_out.sum;
    assign o_out.last_of_row = r_out.last;
endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the depthwise 1-d convolution core: a directed
// table of loads and samples, then random rows under several register
// settings and idle patterns, all checked against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_top;
    import dwc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int WD_LIMIT   = 30000;
    localparam int DRAIN_WAIT = 60;

    typedef struct {
        logic [CH_W-1:0]         ch;
        logic [POS_W-1:0]        pos;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } conv_out_t;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic [CH_W-1:0]         ch;
        logic [TAP_W-1:0]        tap;
        logic [VAL_W-1:0]        val;
        logic                    typed;
        logic signed [SUM_W-1:0] sum;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    dwc_in_if  in_if ();
    dwc_out_if out_if ();

    depthwise_conv1d_forward_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic signed [SMP_W-1:0] coef_mem [DEF_MAX_CHANNELS*DEF_MAX_TAPS];
    logic signed [VAL_W-1:0] bias_mem [DEF_MAX_CHANNELS];
    logic signed [SMP_W-1:0] row_win  [DEF_WINDOW_DEPTH];
    int unsigned rx_cnt, nxt_pos;
    int unsigned r_width, r_ksize, r_stride, r_dil, r_padl, r_padr, r_bias;

    conv_out_t pending_outs[$];
    int errors = 0;
    int outs_checked = 0;
    int items_sent = 0;
    int phases_run = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int wd_cnt = 0;

    function automatic logic signed [SMP_W-1:0] clip_q88(input logic signed [VAL_W-1:0] v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[SMP_W-1:0];
    endfunction

    function automatic int unsigned lim(input int unsigned v, input int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [VAL_W-1:0] rnd_val();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3: return $urandom;
            default: return VAL_W'($signed(17'($urandom_range(0, 65535)) - 17'sd32768));
        endcase
    endfunction

    task automatic predict_conv(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                                input logic [TAP_W-1:0] tap, input logic [VAL_W-1:0] val);
        longint w, kn, st, dl, pl, eff_k, eff_in, outw, cnt, pos, last_in, iw, acc;
        int n;
        conv_out_t r;
        n = 0;
        if (kind == KIND_WEIGHT) begin
            coef_mem[ch*DEF_MAX_TAPS + tap] = clip_q88(val);
            items_sent++;
        end else if (kind == KIND_BIAS) begin
            bias_mem[ch] = val;
            items_sent++;
        end else if (kind == KIND_SAMPLE) begin
            items_sent++;
            row_win[rx_cnt % DEF_WINDOW_DEPTH] = clip_q88(val);
            rx_cnt = (rx_cnt + 1) & 13'h1FFF;
            w = lim(r_width, DEF_MAX_WIDTH);
            kn = lim(r_ksize, DEF_MAX_TAPS);
            st = lim(r_stride, STRIDE_MAX);
            dl = lim(r_dil, DIL_MAX);
            pl = r_padl;
            eff_k = (kn - 1) * dl + 1;
            eff_in = w + pl + r_padr;
            outw = (eff_in < eff_k) ? 0 : (eff_in - eff_k) / st + 1;
            cnt = rx_cnt;
            while (n < RESULT_LIMIT && nxt_pos < outw) begin
                pos = nxt_pos;
                last_in = pos * st + (kn - 1) * dl - pl;
                if (last_in > w - 1) last_in = w - 1;
                if (last_in >= cnt) break;
                acc = 0;
                for (longint k = 0; k < kn; k++) begin
                    iw = pos * st + k * dl - pl;
                    if (iw >= 0 && iw < w && iw < cnt)
                        acc += longint'(row_win[iw % DEF_WINDOW_DEPTH])
                             * longint'(coef_mem[ch*DEF_MAX_TAPS + k]);
                end
                if (r_bias != 0) acc += longint'(bias_mem[ch]);
                r.ch = ch;
                r.pos = pos[POS_W-1:0];
                r.sum = acc[SUM_W-1:0];
                r.last = (pos == outw - 1);
                pending_outs.push_back(r);
                n++;
                nxt_pos = (nxt_pos + 1) & 13'h1FFF;
            end
            if (cnt >= w) begin
                rx_cnt = 0;
                nxt_pos = 0;
            end
        end
    endtask

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                             input logic [TAP_W-1:0] tap, input logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind <= kind;
        in_if.channel <= ch;
        in_if.tap <= tap;
        in_if.value <= val;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_conv(kind, ch, tap, val);
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending_outs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input int unsigned data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_IN_WIDTH:    r_width = data & 13'h1FFF;
            CFG_KERNEL_SIZE: r_ksize = data & 5'h1F;
            CFG_STRIDE:      r_stride = data & 4'hF;
            CFG_DILATION:    r_dil = data & 4'hF;
            CFG_PAD_LEFT:    r_padl = data & 4'hF;
            CFG_PAD_RIGHT:   r_padr = data & 4'hF;
            CFG_BIAS_ENABLE: r_bias = data & 1;
            default: ;
        endcase
    endtask

    task automatic set_conv(input int unsigned w, k, s, d, pl, pr, be);
        drain();
        cfg_write(CFG_IN_WIDTH, w);
        cfg_write(CFG_KERNEL_SIZE, k);
        cfg_write(CFG_STRIDE, s);
        cfg_write(CFG_DILATION, d);
        cfg_write(CFG_PAD_LEFT, pl);
        cfg_write(CFG_PAD_RIGHT, pr);
        cfg_write(CFG_BIAS_ENABLE, be);
        i_cfg_we <= 1'b0;
        phases_run++;
    endtask

    task automatic send_rows(input int rows, input int noise_pct);
        logic [CH_W-1:0] ch;
        int w;
        w = lim(r_width, DEF_MAX_WIDTH);
        for (int r = 0; r < rows; r++) begin
            ch = $urandom;
            for (int i = 0; i < w; i++) begin
                if ($urandom_range(0, 99) < noise_pct) begin
                    case ($urandom_range(0, 2))
                        0: send_item(KIND_NONE, $urandom, $urandom, $urandom);
                        1: send_item(KIND_WEIGHT, $urandom, $urandom, rnd_val());
                        default: send_item(KIND_BIAS, $urandom, $urandom, $urandom);
                    endcase
                end
                if ($urandom_range(0, 9) == 0) ch = $urandom;
                send_item(KIND_SAMPLE, ch, $urandom, rnd_val());
            end
        end
    endtask

    // result side: checking, stalls and the long hold-off
    always @(posedge i_clk) begin
        conv_out_t e;
        if (out_if.valid && out_if.ready) begin
            if (pending_outs.size() == 0) begin
                $display("%0t unexpected transaction ch=%0d pos=%0d sum=%0d last=%0b",
                         $time, out_if.out_channel, out_if.position, out_if.sum_value,
                         out_if.last_of_row);
                errors++;
            end else begin
                e = pending_outs.pop_front();
                outs_checked++;
                if (out_if.out_channel !== e.ch || out_if.position !== e.pos ||
                    out_if.sum_value !== e.sum || out_if.last_of_row !== e.last) begin
                    $display("%0t mismatch exp ch=%0d pos=%0d sum=%0d last=%0b", $time,
                             e.ch, e.pos, e.sum, e.last);
                    $display("%0t          got ch=%0d pos=%0d sum=%0d last=%0b", $time,
                             out_if.out_channel, out_if.position, out_if.sum_value,
                             out_if.last_of_row);
                    errors++;
                end
            end
        end
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !i_rst_n)
            wd_cnt <= 0;
        else
            wd_cnt <= wd_cnt + 1;
        if (wd_cnt >= WD_LIMIT) begin
            $display("%0t watchdog expired, %0d transactions outstanding", $time,
                     pending_outs.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    dir_row_t dir_tab [] = '{
        '{KIND_WEIGHT, 6'd0,  4'd0,  32'h0000_0100, 1'b0, 40'sd0},
        '{KIND_BIAS,   6'd0,  4'd0,  32'h0000_0000, 1'b0, 40'sd0},
        '{KIND_SAMPLE, 6'd0,  4'd0,  32'h7FFF_FFFF, 1'b1, 40'sd8388352},
        '{KIND_SAMPLE, 6'd0,  4'd15, 32'h8000_0000, 1'b1, -40'sd8388608},
        '{KIND_WEIGHT, 6'd63, 4'd0,  32'h0000_7FFF, 1'b0, 40'sd0},
        '{KIND_BIAS,   6'd63, 4'd0,  32'h7FFF_FFFF, 1'b0, 40'sd0},
        '{KIND_SAMPLE, 6'd63, 4'd0,  32'h0000_7FFF, 1'b1, 40'sd3221159936},
        '{KIND_WEIGHT, 6'd63, 4'd0,  32'hFFFF_8000, 1'b0, 40'sd0},
        '{KIND_BIAS,   6'd63, 4'd0,  32'h8000_0000, 1'b0, 40'sd0},
        '{KIND_SAMPLE, 6'd63, 4'd0,  32'hFFFF_8000, 1'b1, -40'sd1073741824},
        '{KIND_NONE,   6'd5,  4'd9,  32'hA5A5_5A5A, 1'b0, 40'sd0},
        '{KIND_WEIGHT, 6'd63, 4'd15, 32'h1234_5678, 1'b0, 40'sd0},
        '{KIND_SAMPLE, 6'd0,  4'd0,  32'h0000_0080, 1'b1, 40'sd32768},
        '{KIND_BIAS,   6'd0,  4'd0,  32'hFFFF_FFFF, 1'b0, 40'sd0},
        '{KIND_SAMPLE, 6'd0,  4'd0,  32'h0000_0000, 1'b1, -40'sd1},
        '{KIND_WEIGHT, 6'd0,  4'd0,  32'h7FFF_FFFF, 1'b0, 40'sd0},
        '{KIND_SAMPLE, 6'd0,  4'd0,  32'hFFFF_FFFF, 1'b1, -40'sd32768}
    };

    initial begin
        int rand_start, outs_start, p, w;
        conv_out_t r;
        in_if.valid = 1'b0;
        in_if.kind = '0;
        in_if.channel = '0;
        in_if.tap = '0;
        in_if.value = '0;
        out_if.ready = 1'b0;
        rx_cnt = 0;
        nxt_pos = 0;
        r_width = 16; r_ksize = 3; r_stride = 1; r_dil = 1;
        r_padl = 0; r_padr = 0; r_bias = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, one sample per row, single tap
        set_conv(1, 1, 1, 1, 0, 0, 1);
        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].kind, dir_tab[i].ch, dir_tab[i].tap, dir_tab[i].val);
            if (dir_tab[i].typed) begin
                r = pending_outs.pop_back();
                r.sum = dir_tab[i].sum;
                pending_outs.push_back(r);
            end
        end
        drain();

        // every weight and bias written before any wider kernel runs
        for (int c = 0; c < DEF_MAX_CHANNELS; c++) begin
            for (int t = 0; t < DEF_MAX_TAPS; t++) send_item(KIND_WEIGHT, c, t, rnd_val());
            send_item(KIND_BIAS, c, $urandom, $urandom);
        end

        // zero registers clamp up, pads give 31 outputs from one sample
        set_conv(0, 0, 0, 0, 15, 15, 1);
        send_rows(3, 0);
        set_conv(16, 3, 1, 1, 0, 0, 1);
        send_rows(2, 0);
        // kernel span longer than the row
        set_conv(5, 16, 1, 8, 0, 0, 1);
        send_rows(2, 0);
        set_conv(37, 5, 8, 2, 3, 7, 0);
        send_rows(2, 5);
        // widest rows, registers above range
        set_conv(8191, 31, 15, 15, 15, 15, 1);
        send_rows(1, 0);
        set_conv(4096, 1, 1, 1, 15, 15, 0);
        send_rows(1, 0);

        // long result hold-off while samples keep coming
        set_conv(24, 1, 1, 1, 0, 0, 1);
        hold_req = 800;
        send_rows(3, 0);

        rand_start = items_sent;
        outs_start = outs_checked;
        p = 0;
        while (items_sent - rand_start < 280 || outs_checked - outs_start < 60) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 130) : $urandom_range(1, 24);
            set_conv(w, $urandom_range(0, 31), $urandom_range(0, 15),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3),
                     $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            send_rows($urandom_range(1, 3), 5);
            if (p == 2) drain();
            send_rows(1, 5);
            p++;
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("run covered %0d accepted items over %0d register settings", items_sent,
                 phases_run);
        $display("%0d results checked, %0d failures", outs_checked, errors);
        if (errors == 0 && pending_outs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
